// ----- rtl/pcmdc_pkg.sv -----
// Shared types, mode codes and quantizer constants for the PCM down-converter.
// Used by the channel interfaces, the datapath and the core.
package pcmdc_pkg;

  // Conversion mode register codes
  typedef enum logic [1:0] {
    MODE_REDUCE       = 2'd0,
    MODE_HALVE16      = 2'd1,
    MODE_HALVE8       = 2'd2,
    MODE_HALVE_REDUCE = 2'd3
  } mode_t;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned Q_W      = 18;
  localparam int unsigned RND_W    = 11;

  // Per-mode rounding offset, mask of the bits below the step, and top code
  typedef struct packed {
    logic [RND_W-1:0] round;
    logic [RND_W-1:0] low_mask;
    logic [Q_W-1:0]   top;
  } quant_cfg_t;

  // Held state that the datapath reads for one transaction
  typedef struct packed {
    logic [ERR_W-1:0]    err;
    logic [SAMPLE_W-1:0] prev;
    logic [SAMPLE_W-1:0] first;
  } dp_state_t;

  // What the datapath hands back for one transaction
  typedef struct packed {
    logic [ERR_W-1:0]    err_next;
    logic [SAMPLE_W-1:0] sample;
  } dp_result_t;

  function automatic quant_cfg_t quant_cfg(input mode_t mode);
    quant_cfg_t c;
    unique case (mode)
      MODE_REDUCE: begin
        c.round    = 11'd127;
        c.low_mask = 11'h0ff;
        c.top      = 18'h0ff00;
      end
      MODE_HALVE16: begin
        c.round    = 11'd2;
        c.low_mask = 11'h003;
        c.top      = 18'h3fffc;
      end
      MODE_HALVE8: begin
        c.round    = 11'd2;
        c.low_mask = 11'h003;
        c.top      = 18'h003fc;
      end
      MODE_HALVE_REDUCE: begin
        c.round    = 11'd512;
        c.low_mask = 11'h3ff;
        c.top      = 18'h3fc00;
      end
      default: begin
        c.round    = 11'd127;
        c.low_mask = 11'h0ff;
        c.top      = 18'h0ff00;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/pcmdc_stream_if.sv -----
// Valid/ready stream channels for the PCM down-converter input and result.
// Depends on pcmdc_pkg for the sample width.
interface pcmdc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pcmdc_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 start_of_clip;

  modport source(output valid, output sample_in, output start_of_clip, input ready);
  modport sink(input valid, input sample_in, input start_of_clip, output ready);
endinterface

interface pcmdc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pcmdc_pkg::SAMPLE_W-1:0] sample_out;

  modport source(output valid, output sample_out, input ready);
  modport sink(input valid, input sample_out, output ready);
endinterface

// ----- rtl/pcmdc_datapath.sv -----
// Filter, error-diffusion quantizer and output formatting for one transaction.
// Depends on pcmdc_pkg for mode codes, quantizer constants and state structs.
module pcmdc_datapath (
  input  pcmdc_pkg::mode_t                    mode,
  input  logic                                start,
  input  logic [pcmdc_pkg::SAMPLE_W-1:0]      sample,
  input  pcmdc_pkg::dp_state_t                state,
  output pcmdc_pkg::dp_result_t               result
);

  pcmdc_pkg::quant_cfg_t        qc;
  logic [pcmdc_pkg::ERR_W-1:0]  err_eff;
  logic signed [19:0]           sum_signed;
  logic [9:0]                   sum_bytes;
  logic [pcmdc_pkg::ERR_W-1:0]  value;
  logic [pcmdc_pkg::ERR_W-1:0]  orig;
  logic signed [32:0]           t;
  logic [pcmdc_pkg::ERR_W-1:0]  t_masked;
  logic [pcmdc_pkg::Q_W-1:0]    q;
  logic [pcmdc_pkg::ERR_W-1:0]  err_next;
  logic [pcmdc_pkg::SAMPLE_W-1:0] sample_fmt;

  assign qc      = pcmdc_pkg::quant_cfg(mode);
  assign err_eff = start ? '0 : state.err;

  // 1-2-1 pair filter on signed samples and on unsigned bytes
  assign sum_signed = 20'(signed'(state.prev)) + 20'(signed'(state.first))
                    + 20'(signed'(state.first)) + 20'(signed'(sample));
  assign sum_bytes  = 10'(state.prev[7:0]) + 10'(state.first[7:0])
                    + 10'(state.first[7:0]) + 10'(sample[7:0]);

  // Offset the value so it is unsigned before quantizing
  always_comb begin
    unique case (mode)
      pcmdc_pkg::MODE_REDUCE:
        value = 32'(signed'(sample)) + 32'd32768;
      pcmdc_pkg::MODE_HALVE8:
        value = 32'(sum_bytes);
      pcmdc_pkg::MODE_HALVE16, pcmdc_pkg::MODE_HALVE_REDUCE:
        value = 32'(sum_signed) + 32'd131072;
      default:
        value = 32'(signed'(sample)) + 32'd32768;
    endcase
  end

  // Add the carried error, round down to the step, clamp to 0..top
  assign orig     = err_eff + value;
  assign t        = signed'({orig[31], orig}) + signed'(33'(qc.round));
  assign t_masked = t[31:0] & ~(32'(qc.low_mask));

  always_comb begin
    priority if (t[32]) begin
      q = '0;
    end else if (t_masked > 32'(qc.top)) begin
      q = qc.top;
    end else begin
      q = t_masked[pcmdc_pkg::Q_W-1:0];
    end
  end

  assign err_next = orig - 32'(q);

  // Scale the quantized value back to the output code
  always_comb begin
    unique case (mode)
      pcmdc_pkg::MODE_REDUCE:       sample_fmt = {8'd0, q[15:8]};
      pcmdc_pkg::MODE_HALVE16:      sample_fmt = {~q[17], q[16:2]};
      pcmdc_pkg::MODE_HALVE8:       sample_fmt = {8'd0, q[9:2]};
      pcmdc_pkg::MODE_HALVE_REDUCE: sample_fmt = {8'd0, q[17:10]};
      default:                      sample_fmt = {8'd0, q[15:8]};
    endcase
  end

  assign result = '{err_next: err_next, sample: sample_fmt};

endmodule

// ----- rtl/pcm_downconvert_error_diffusion_core.sv -----
// PCM down-converter with error-diffusion dither: one sample per clock in every mode while
// the output is not stalled. A transaction is registered at the input, processed against
// the error, pair phase and held samples, and the result lands in an output register, so
// a result passes through the input register and then the output register. The loop from
// the error register through the error add, step mask, clamp and subtract sets the rate.
// Mode 0 gives one result per input; the halving modes give one per pair and drop a trailing odd sample.
// The output register lets the next input be taken while a result waits.
// Depends on pcmdc_pkg, pcmdc_stream_if and pcmdc_datapath.
module pcm_downconvert_error_diffusion_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_data,
  pcmdc_in_if.sink          in_ch,
  pcmdc_out_if.source       out_ch
);

  pcmdc_pkg::mode_t                  mode;
  logic                              s1_valid;
  logic [pcmdc_pkg::SAMPLE_W-1:0]    s1_sample;
  logic                              s1_start;
  logic [pcmdc_pkg::ERR_W-1:0]       err;
  logic [pcmdc_pkg::SAMPLE_W-1:0]    prev;
  logic [pcmdc_pkg::SAMPLE_W-1:0]    first;
  logic                              phase;
  logic                              out_valid;
  logic [pcmdc_pkg::SAMPLE_W-1:0]    out_sample;

  logic                              phase_eff;
  logic                              gives_result;
  logic                              s1_advance;
  logic                              s1_fire;
  logic                              in_fire;
  pcmdc_pkg::dp_state_t              dp_state;
  pcmdc_pkg::dp_result_t             dp_result;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pcmdc_pkg::MODE_REDUCE;
    end else if (cfg_write) begin
      mode <= pcmdc_pkg::mode_t'(cfg_data);
    end
  end

  // Handshake: stage one drains when it makes no result or the output slot frees
  assign phase_eff    = s1_start ? 1'b0 : phase;
  assign gives_result = (mode == pcmdc_pkg::MODE_REDUCE) || phase_eff;
  assign s1_advance   = !gives_result || !out_valid || out_ch.ready;
  assign s1_fire      = s1_valid && s1_advance;
  assign in_ch.ready  = !rst && (!s1_valid || s1_advance);
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= in_ch.sample_in;
      s1_start  <= in_ch.start_of_clip;
    end
  end

  assign dp_state = '{err: err, prev: prev, first: first};

  pcmdc_datapath u_datapath (
    .mode   (mode),
    .start  (s1_start),
    .sample (s1_sample),
    .state  (dp_state),
    .result (dp_result)
  );

  // Update error, held samples and pair phase as each transaction retires
  always_ff @(posedge clk) begin
    if (rst) begin
      err   <= '0;
      prev  <= '0;
      first <= '0;
      phase <= 1'b0;
    end else if (s1_fire) begin
      if (mode == pcmdc_pkg::MODE_REDUCE) begin
        err <= dp_result.err_next;
        if (s1_start) begin
          prev  <= s1_sample;
          phase <= 1'b0;
        end
      end else if (!phase_eff) begin
        err   <= s1_start ? '0 : err;
        first <= s1_sample;
        phase <= 1'b1;
        if (s1_start) begin
          prev <= s1_sample;
        end
      end else begin
        err   <= dp_result.err_next;
        prev  <= s1_sample;
        phase <= 1'b0;
      end
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && gives_result) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && gives_result) begin
      out_sample <= dp_result.sample;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;

endmodule

// ----- rtl/pcmdc_checker.sv -----
// Port-level checks for the PCM down-converter core, bound into the core module.
// Depends on pcmdc_pkg for the mode codes.
module pcmdc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_write,
  input logic [1:0]                      cfg_data,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pcmdc_pkg::SAMPLE_W-1:0]  sample_out
);

  pcmdc_pkg::mode_t mode;

  // Track the mode as written on the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pcmdc_pkg::MODE_REDUCE;
    end else if (cfg_write) begin
      mode <= pcmdc_pkg::mode_t'(cfg_data);
    end
  end

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("stalled result changed");

  // Byte modes never set the upper byte
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode != pcmdc_pkg::MODE_HALVE16 |-> sample_out[15:8] == 8'd0)
    else $error("byte result out of range");

  // A fresh result follows an input transaction through the input and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input");

endmodule

bind pcm_downconvert_error_diffusion_core pcmdc_checker u_pcmdc_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_write  (cfg_write),
  .cfg_data   (cfg_data),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pcm_downconvert_error_diffusion_core, all four modes.
// Depends on pcmdc_pkg, the pcmdc_in_if/pcmdc_out_if channels and the core RTL.
module testbench;

  // Predicts each output sample and checks the block's results in order
  class dither_scoreboard;
    pcmdc_pkg::mode_t mode;
    bit [31:0]   err;
    bit [15:0]   prev;
    bit [15:0]   first;
    bit          phase;
    logic [15:0] expected_samples[$];
    int          failures;

    function new();
      mode     = pcmdc_pkg::MODE_REDUCE;
      err      = '0;
      prev     = '0;
      first    = '0;
      phase    = 1'b0;
      failures = 0;
    endfunction

    // Add value to the carried error, round down to the step, clamp, keep the remainder
    function longint quantize_feedback(longint value, longint rnd, longint step,
                                       longint top);
      bit [31:0] orig;
      longint    t;
      longint    q;
      orig = err + 32'(value);
      t = longint'(signed'(orig)) + rnd;
      if (t < 0) q = 0;
      else q = t - (t % step);
      if (q > top) q = top;
      err = orig - 32'(q);
      return q;
    endfunction

    // Advance the predicted state by one accepted transaction
    function void take_sample(logic [15:0] raw, logic sop);
      longint p;
      longint f;
      longint s;
      longint q;
      if (sop) begin
        err   = '0;
        prev  = raw;
        phase = 1'b0;
      end
      if (mode == pcmdc_pkg::MODE_REDUCE) begin
        q = quantize_feedback(32768 + longint'($signed(raw)), 127, 256, 'hff00);
        expected_samples.push_back(16'(q / 256));
        return;
      end
      // hold the even sample of the pair
      if (!phase) begin
        first = raw;
        phase = 1'b1;
        return;
      end
      phase = 1'b0;
      if (mode == pcmdc_pkg::MODE_HALVE8) begin
        p = prev[7:0];
        f = first[7:0];
        s = raw[7:0];
        prev = raw;
        q = quantize_feedback(p + 2 * f + s, 2, 4, 'h3fc);
        expected_samples.push_back(16'((q / 4) & 'hff));
      end else begin
        p = longint'($signed(prev));
        f = longint'($signed(first));
        s = longint'($signed(raw));
        prev = raw;
        if (mode == pcmdc_pkg::MODE_HALVE16) begin
          q = quantize_feedback(131072 + p + 2 * f + s, 2, 4, 'h3fffc);
          expected_samples.push_back(16'(((q / 4) ^ 'h8000) & 'hffff));
        end else begin
          q = quantize_feedback(131072 + p + 2 * f + s, 512, 1024, 'h3fc00);
          expected_samples.push_back(16'((q / 1024) & 'hff));
        end
      end
    endfunction

    function void check_output_sample(logic [15:0] got);
      logic [15:0] want;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample_out, expected none, got %h", $time, got);
        failures++;
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out expected %h, got %h", $time, want, got);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_data;

  pcmdc_in_if  in_ch();
  pcmdc_out_if out_ch();

  dither_scoreboard sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_cycles    = 0;

  pcm_downconvert_error_diffusion_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive ready: a long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_output_sample(out_ch.sample_out);
  end

  task automatic send_item(input logic [15:0] smp, input logic sop);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample_in     <= smp;
    in_ch.start_of_clip <= sop;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_sample(smp, sop);
  endtask

  // Wait for all expected results, then let a trailing odd sample settle
  task automatic drain();
    int n;
    for (n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input pcmdc_pkg::mode_t m);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.mode = m;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      // byte data as the 8-bit mode expects
      2, 3: return {8'h00, 8'($urandom_range(255))};
      4: return 16'($urandom_range(63)) - 16'd32;
      5: return ($urandom_range(1) != 0) ? 16'h00ff : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int seg;
    int i;
    int count;
    int profile;
    logic sop;

    sb = new();
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_data            = pcmdc_pkg::MODE_REDUCE;
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.start_of_clip = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reduce mode: extremes, clamp at the top code
    write_mode(pcmdc_pkg::MODE_REDUCE);
    send_item(16'h8000, 1'b1);
    send_item(16'h7fff, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'hffff, 1'b0);
    send_item(16'h7fff, 1'b0);
    send_item(16'h7fff, 1'b0);
    in_ch.valid <= 1'b0;
    drain();

    // Halve 16-bit: full-scale positive and negative pairs
    write_mode(pcmdc_pkg::MODE_HALVE16);
    send_item(16'h7fff, 1'b1);
    send_item(16'h7fff, 1'b0);
    send_item(16'h7fff, 1'b0);
    send_item(16'h7fff, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    in_ch.valid <= 1'b0;
    drain();

    // Halve 8-bit with a trailing odd sample, then change mode mid-pair
    write_mode(pcmdc_pkg::MODE_HALVE8);
    send_item(16'h00ff, 1'b1);
    send_item(16'h00ff, 1'b0);
    send_item(16'h00ff, 1'b0);
    in_ch.valid <= 1'b0;
    drain();
    write_mode(pcmdc_pkg::MODE_HALVE_REDUCE);
    send_item(16'h7fff, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(16'h1234, 1'b0);
    in_ch.valid <= 1'b0;
    drain();

    // Leave a negative error in reduce mode, then saturate at zero in 8-bit mode
    write_mode(pcmdc_pkg::MODE_REDUCE);
    send_item(16'h0000, 1'b1);
    send_item(16'h0081, 1'b0);
    in_ch.valid <= 1'b0;
    drain();
    write_mode(pcmdc_pkg::MODE_HALVE8);
    send_item(16'h0000, 1'b0);
    send_item(16'h0000, 1'b0);
    in_ch.valid <= 1'b0;

    // Random clips, mostly opened by a start flag, under varied idling
    for (seg = 0; seg < 15; seg++) begin
      drain();
      write_mode((seg < 8) ? pcmdc_pkg::mode_t'(seg % 4)
                           : pcmdc_pkg::mode_t'($urandom_range(3)));
      profile = (seg + seg / 4) % 4;
      case (profile)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      count = 20 + $urandom_range(20);
      for (i = 0; i < count; i++) begin
        // hold off the receiver so the block backs up into its input
        if (seg == 4 && i == 5) hold_cycles = 150;
        // pause the sender until all results are out
        if (seg == 6 && i == count / 2) begin
          in_ch.valid <= 1'b0;
          drain();
        end
        if (i == 0) sop = ($urandom_range(99) < 85);
        else sop = ($urandom_range(99) < 3);
        send_item(pick_sample(), sop);
      end
      in_ch.valid <= 1'b0;
    end

    drain();
    if (sb.pending() != 0) $display("%0t: %0d expected results never arrived",
                                    $time, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[pcm_downconvert_error_diffusion_core] OK");
    end else begin
      $display("[pcm_downconvert_error_diffusion_core] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[pcm_downconvert_error_diffusion_core] ERROR");
    $finish;
  end

endmodule

// ----- pcm_downconvert_error_diffusion_core.f -----
rtl/pcmdc_pkg.sv
rtl/pcmdc_stream_if.sv
rtl/pcmdc_datapath.sv
rtl/pcm_downconvert_error_diffusion_core.sv
rtl/pcmdc_checker.sv
tb/sv/testbench.sv
